>>> rtl/dhot_pkg.sv
// ----------------------------------------------------------------------------
// dhot_pkg
// Shared types and constants for the double-hashed open-addressed key table.
// ----------------------------------------------------------------------------
package dhot_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int SLOT_W      = 8;    // slot index bits
    localparam int LINK_W      = 9;    // link index bits, sentinel included
    localparam int CNT_W       = 9;
    localparam int KEY_W       = 32;
    localparam int HASH_W      = 32;

    localparam logic [LINK_W-1:0] SENTINEL = LINK_W'(TABLE_DEPTH);

    // opcodes
    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_LOOKUP  = 3'd2;
    localparam logic [2:0] OP_RESTART = 3'd3;
    localparam logic [2:0] OP_NEXT    = 3'd4;

    // status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_LIMIT    = 3'd2;
    localparam logic [2:0] ST_NOSLOT   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_WALKEND  = 3'd5;

    // slot marks
    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_VACATED = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SLOTS = 2'd0;
    localparam logic [1:0] CFG_MAX   = 2'd1;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash_first;
        logic [HASH_W-1:0] hash_second;
    } in_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [KEY_W-1:0] key_out;
        logic [CNT_W-1:0] entry_total;
    } out_t;

endpackage

>>> rtl/double_hash_open_table_core.sv
// ----------------------------------------------------------------------------
// double_hash_open_table_core
// Open-addressed key table with double hashing and an insertion-order list.
// ----------------------------------------------------------------------------
// Each probe runs the shared 4-bit-per-cycle remainder unit over the hash, then
//   one memory read and one check. After the last probe a lookup goes to the
//   output; an insert first writes the key, mark and links; a remove reads the
//   links and then unlinks the slot. Walk next reads the link, then the key, then
//   finishes; restart, refused insert, walk end and unknown opcode go straight to the output.
// One transaction at a time; the next is taken in the cycle after the result has
//   been accepted. Reset clears all slot marks at once (per-slot valid bits).
module double_hash_open_table_core
    import dhot_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_wdata
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MOD    = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_INS    = 4'd4;
    localparam logic [3:0] S_RM_RD  = 4'd5;
    localparam logic [3:0] S_RM_WR  = 4'd6;
    localparam logic [3:0] S_WK_RD  = 4'd7;
    localparam logic [3:0] S_WK_KEY = 4'd8;
    localparam logic [3:0] S_WK_FIN = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    // memories and their registered read data
    logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
    logic [1:0]        mark_mem [TABLE_DEPTH];
    logic [LINK_W-1:0] next_mem [TABLE_DEPTH+1];
    logic [LINK_W-1:0] prev_mem [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] mark_vld_reg;

    logic [KEY_W-1:0]  key_q;
    logic [1:0]        mark_q;
    logic              vld_q;
    logic [LINK_W-1:0] next_q;
    logic [LINK_W-1:0] prev_q;

    // control and item registers
    logic [3:0]        state_reg, state_next;
    logic [8:0]        slots_reg, max_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    logic [LINK_W-1:0] cursor_reg, cursor_next;
    logic              m_valid_reg, m_valid_next;
    out_t              out_reg, out_next;

    logic [2:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [HASH_W-1:0] stride_reg;
    logic [8:0]        n_reg;
    logic [HASH_W-1:0] acc_reg, acc_next;
    logic [8:0]        probe_reg, probe_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] free_reg, free_next;
    logic              free_vld_reg, free_vld_next;

    // shared remainder unit
    logic [HASH_W-1:0] div_reg, div_next;
    logic [8:0]        rem_reg, rem_next;
    logic [2:0]        step_reg, step_next;

    // memory write controls
    logic              key_we, mark_we, nlink_we, plink_we;
    logic [SLOT_W-1:0] key_waddr, mark_waddr;
    logic [1:0]        mark_wdata;
    logic [LINK_W-1:0] nlink_waddr, nlink_wdata, plink_waddr, plink_wdata;
    logic [SLOT_W-1:0] key_raddr;
    logic [LINK_W-1:0] nlink_raddr;

    logic [1:0]        mark_eff;
    logic [8:0]        n_eff;
    logic [8:0]        probe_inc;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;
    assign mark_eff = vld_q ? mark_q : MARK_EMPTY;
    assign probe_inc = probe_reg + 9'd1;

    // effective slot count: zero acts as one, cap at table size
    always_comb begin
        if (slots_reg == 9'd0) begin
            n_eff = 9'd1;
        end else if (slots_reg > 9'(TABLE_DEPTH)) begin
            n_eff = 9'(TABLE_DEPTH);
        end else begin
            n_eff = slots_reg;
        end
    end

    // remainder unit: four restoring steps per cycle
    always_comb begin
        logic [8:0] r;
        r = rem_reg;
        for (int b = 0; b < 4; b++) begin
            r = {r[7:0], div_reg[HASH_W-1-b]};
            if (r >= n_reg) begin
                r = r - n_reg;
            end
        end
        rem_next = r;
    end

    // read addresses
    assign key_raddr   = (state_reg == S_WK_KEY) ? next_q[SLOT_W-1:0] : slot_reg;
    assign nlink_raddr = (state_reg == S_WK_RD) ? cursor_reg : {1'b0, slot_reg};

    // sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        tail_next     = tail_reg;
        cursor_next   = cursor_reg;
        m_valid_next  = m_valid_reg;
        out_next      = out_reg;
        acc_next      = acc_reg;
        probe_next    = probe_reg;
        slot_next     = slot_reg;
        free_next     = free_reg;
        free_vld_next = free_vld_reg;
        div_next      = div_reg;
        step_next     = step_reg;
        key_we = 1'b0;  key_waddr = slot_reg;
        mark_we = 1'b0; mark_waddr = slot_reg; mark_wdata = MARK_USED;
        nlink_we = 1'b0; nlink_waddr = tail_reg; nlink_wdata = {1'b0, slot_reg};
        plink_we = 1'b0; plink_waddr = {1'b0, slot_reg}; plink_wdata = tail_reg;
        out_next.entry_total = count_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    acc_next      = s_data.hash_first;
                    div_next      = s_data.hash_first;
                    probe_next    = 9'd0;
                    step_next     = 3'd0;
                    free_vld_next = 1'b0;
                    out_next.key_out = '0;
                    state_next    = S_OUT;
                    m_valid_next  = 1'b1;
                    case (s_data.opcode)
                        OP_INSERT: begin
                            if (count_reg == max_reg) begin
                                out_next.status = ST_LIMIT;
                            end else begin
                                state_next   = S_MOD;
                                m_valid_next = 1'b0;
                            end
                        end
                        OP_REMOVE, OP_LOOKUP: begin
                            state_next   = S_MOD;
                            m_valid_next = 1'b0;
                        end
                        OP_RESTART: begin
                            cursor_next     = SENTINEL;
                            out_next.status = ST_DONE;
                        end
                        OP_NEXT: begin
                            if (cursor_reg == tail_reg) begin
                                out_next.status = ST_WALKEND;
                            end else begin
                                state_next   = S_WK_RD;
                                m_valid_next = 1'b0;
                            end
                        end
                        default: begin
                            out_next.status = ST_NOTFOUND;
                        end
                    endcase
                end
            end
            S_MOD: begin
                div_next  = {div_reg[HASH_W-5:0], 4'd0};
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7) begin
                    slot_next  = rem_next[SLOT_W-1:0];
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                state_next = S_OUT;
                out_next.key_out = '0;
                if (mark_eff == MARK_EMPTY) begin
                    if (op_reg == OP_INSERT) begin
                        if (!free_vld_reg) begin
                            free_next = slot_reg;
                        end
                        state_next = S_INS;
                    end else begin
                        out_next.status = ST_NOTFOUND;
                    end
                end else if (mark_eff == MARK_USED && key_q == key_reg) begin
                    case (op_reg)
                        OP_INSERT: out_next.status = ST_PRESENT;
                        OP_REMOVE: state_next = S_RM_RD;
                        default: begin
                            out_next.status  = ST_DONE;
                            out_next.key_out = key_q;
                        end
                    endcase
                end else begin
                    if (mark_eff != MARK_USED && !free_vld_reg) begin
                        free_vld_next = 1'b1;
                        free_next     = slot_reg;
                    end
                    if (probe_inc == n_reg) begin
                        // probe sequence exhausted
                        if (op_reg == OP_INSERT) begin
                            if (free_vld_reg || mark_eff != MARK_USED) begin
                                state_next = S_INS;
                            end else begin
                                out_next.status = ST_NOSLOT;
                            end
                        end else begin
                            out_next.status = ST_NOTFOUND;
                        end
                    end else begin
                        probe_next = probe_inc;
                        acc_next   = acc_reg + stride_reg;
                        div_next   = acc_reg + stride_reg;
                        step_next  = 3'd0;
                        state_next = S_MOD;
                    end
                end
                if (state_next == S_OUT) begin
                    m_valid_next = 1'b1;
                end
            end
            S_INS: begin
                key_we      = 1'b1;
                key_waddr   = free_reg;
                mark_we     = 1'b1;
                mark_waddr  = free_reg;
                mark_wdata  = MARK_USED;
                nlink_we    = 1'b1;
                nlink_waddr = tail_reg;
                nlink_wdata = {1'b0, free_reg};
                plink_we    = 1'b1;
                plink_waddr = {1'b0, free_reg};
                plink_wdata = tail_reg;
                tail_next   = {1'b0, free_reg};
                count_next  = count_reg + 9'd1;
                out_next.status      = ST_DONE;
                out_next.key_out     = '0;
                out_next.entry_total = count_reg + 9'd1;
                m_valid_next = 1'b1;
                state_next   = S_OUT;
            end
            S_RM_RD: begin
                state_next = S_RM_WR;
            end
            S_RM_WR: begin
                mark_we    = 1'b1;
                mark_wdata = MARK_VACATED;
                if ({1'b0, slot_reg} == tail_reg) begin
                    tail_next = prev_q;
                end else begin
                    nlink_we    = 1'b1;
                    nlink_waddr = prev_q;
                    nlink_wdata = next_q;
                    plink_we    = 1'b1;
                    plink_waddr = next_q;
                    plink_wdata = prev_q;
                end
                count_next = count_reg - 9'd1;
                out_next.status      = ST_DONE;
                out_next.key_out     = key_reg;
                out_next.entry_total = count_reg - 9'd1;
                m_valid_next = 1'b1;
                state_next   = S_OUT;
            end
            S_WK_RD: begin
                state_next = S_WK_KEY;
            end
            S_WK_KEY: begin
                cursor_next = next_q;
                state_next  = S_WK_FIN;
            end
            S_WK_FIN: begin
                out_next.status  = ST_DONE;
                out_next.key_out = (cursor_reg < SENTINEL) ? key_q : '0;
                m_valid_next = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            slots_reg    <= 9'(TABLE_DEPTH);
            max_reg      <= 9'(TABLE_DEPTH);
            count_reg    <= '0;
            tail_reg     <= SENTINEL;
            cursor_reg   <= SENTINEL;
            m_valid_reg  <= 1'b0;
            mark_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            tail_reg    <= tail_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
            if (mark_we) begin
                mark_vld_reg[mark_waddr] <= 1'b1;
            end
            if (cfg_we && cfg_index == CFG_SLOTS) begin
                slots_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_MAX) begin
                max_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        acc_reg      <= acc_next;
        probe_reg    <= probe_next;
        slot_reg     <= slot_next;
        free_reg     <= free_next;
        free_vld_reg <= free_vld_next;
        div_reg      <= div_next;
        step_reg     <= step_next;
        if (state_reg == S_MOD) begin
            rem_reg <= (step_reg == 3'd7) ? 9'd0 : rem_next;
        end else begin
            rem_reg <= 9'd0;
        end
        if (state_reg == S_IDLE && s_valid) begin
            op_reg     <= s_data.opcode;
            key_reg    <= s_data.key;
            stride_reg <= s_data.hash_second;
            n_reg      <= n_eff;
        end
    end

    // key store
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_reg;
        end
        key_q <= key_mem[key_raddr];
    end

    // slot marks
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_q <= mark_mem[slot_reg];
        vld_q  <= mark_vld_reg[slot_reg];
    end

    // forward links
    always_ff @(posedge aclk) begin
        if (nlink_we) begin
            next_mem[nlink_waddr] <= nlink_wdata;
        end
        next_q <= next_mem[nlink_raddr];
    end

    // backward links
    always_ff @(posedge aclk) begin
        if (plink_we) begin
            prev_mem[plink_waddr] <= plink_wdata;
        end
        prev_q <= prev_mem[{1'b0, slot_reg}];
    end

    // checks
    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == S_OUT))
        else $error("result valid outside output state");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 9'(TABLE_DEPTH))
        else $error("entry count above table size");
    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS) |=> (count_reg == $past(count_reg) + 9'd1))
        else $error("insert did not bump entry count");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOD) |-> !s_ready)
        else $error("ready while probing");

endmodule
